// ----- src/bgd_pkg.sv -----
// Shared definitions for the button gesture detector.
// Holds action, key and gesture codes, register indexes, reset values and structs.
// No dependencies.
package bgd_pkg;

	localparam int TIME_BITS_DEF = 64;
	localparam int NOW_W         = 63;
	localparam int MS_W          = 16;
	localparam int TO_W          = 17;
	localparam int CFG_IDX_W     = 2;

	localparam logic [1:0] ACT_KEY   = 2'd0;
	localparam logic [1:0] ACT_POLL  = 2'd1;
	localparam logic [1:0] ACT_QUERY = 2'd2;

	localparam logic [1:0] KEY_RELEASE = 2'd0;
	localparam logic [1:0] KEY_PRESS   = 2'd1;

	localparam logic [1:0] G_NONE   = 2'd0;
	localparam logic [1:0] G_CLICK  = 2'd1;
	localparam logic [1:0] G_LONG   = 2'd2;
	localparam logic [1:0] G_DOUBLE = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_WINDOW = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_EN     = 2'd2;

	localparam logic [MS_W-1:0] LONG_PRESS_RST    = 16'd500;
	localparam logic [MS_W-1:0] DOUBLE_WINDOW_RST = 16'd300;

	// Query answer when nothing is pending: all ones, i.e. -1.
	localparam logic [TO_W-1:0] TO_NONE = 17'h1FFFF;
	localparam logic [MS_W-1:0] TO_SAT  = 16'hFFFF;

	typedef struct packed {
		logic [MS_W-1:0] long_press_ms;
		logic [MS_W-1:0] double_window_ms;
		logic            dbl_click_en;
	} cfg_t;

	// Comparison of the elapsed time since one stored time against a limit.
	typedef struct packed {
		logic            reached;    // elapsed >= limit and not negative
		logic            in_window;  // elapsed <= limit and not negative
		logic [MS_W-1:0] left;       // ms until limit, saturated
	} timer_res_t;

endpackage

// ----- src/button_gesture_detector_top.sv -----
// A result passes the input register, then the result register, before it is offered.
// Throughput: one item per cycle while the output is not stalled; the state update and
// the result are one registered pass. An input register and an output register part the
// two channels, so the next item is taken while a result waits. Reset clears all flags
// and valids and loads the register defaults 500, 300 and 1; the stored press and
// release times need no reset.
// Top level of the button gesture detector. Depends on bgd_pkg and bgd_core.
module button_gesture_detector_top import bgd_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [MS_W-1:0]      cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           action,
	input  logic [1:0]           key_value,
	input  logic [NOW_W-1:0]     now_ms,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           gesture,
	output logic [TO_W-1:0]      timeout_ms
);

	logic                 valid_s1;
	logic [1:0]           action_s1, key_value_s1;
	logic [TIME_BITS-1:0] now_s1;
	logic [TIME_BITS-1:0] now_in;

	logic            in_fire, out_free, advance;
	logic [1:0]      gesture_d;
	logic [TO_W-1:0] timeout_d;
	logic [1:0]      gesture_q;
	logic [TO_W-1:0] timeout_q;
	logic            out_valid_q;

	generate
		if (TIME_BITS > NOW_W) begin : g_wide
			assign now_in = {{(TIME_BITS-NOW_W){1'b0}}, now_ms};
		end else begin : g_narrow
			assign now_in = now_ms[TIME_BITS-1:0];
		end
	endgenerate

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_fire  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			action_s1    <= action;
			key_value_s1 <= key_value;
			now_s1       <= now_in;
		end
		if (advance) begin
			gesture_q <= gesture_d;
			timeout_q <= timeout_d;
		end
	end

	bgd_core #(.TIME_BITS(TIME_BITS)) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fire         (advance),
		.action       (action_s1),
		.key_value    (key_value_s1),
		.now          (now_s1),
		.gesture      (gesture_d),
		.timeout_ms   (timeout_d)
	);

	assign out_valid  = out_valid_q;
	assign gesture    = gesture_q;
	assign timeout_ms = timeout_q;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with an empty input stage");

	a_query_has_no_gesture: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && timeout_ms != TO_NONE |-> gesture == G_NONE)
		else $error("result carries both a timeout and a gesture");

	a_held_item_kept: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid && out_stall |=> valid_s1 && out_valid)
		else $error("item dropped while the output was stalled");

	a_result_follows_advance: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("advanced item did not reach the output register");

endmodule

// ----- src/bgd_timer.sv -----
// Elapsed-time unit: two wrapped subtractions against a stored time and the
// compares against a 16-bit limit. Depends on bgd_pkg.
module bgd_timer import bgd_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic [TIME_BITS-1:0] now,
	input  logic [TIME_BITS-1:0] stamp,
	input  logic [MS_W-1:0]      limit,
	output timer_res_t           res
);

	logic [TIME_BITS-1:0] diff;
	logic [TIME_BITS-1:0] lag;
	logic                 neg;
	logic                 diff_high;
	logic                 lag_sat;
	logic [MS_W:0]        sum;

	assign diff      = now - stamp;
	assign lag       = stamp - now;
	assign neg       = diff[TIME_BITS-1];
	assign diff_high = |diff[TIME_BITS-1:MS_W];
	assign lag_sat   = (|lag[TIME_BITS-1:MS_W]) || (lag[MS_W-1:0] == TO_SAT);
	assign sum       = {1'b0, limit} + {1'b0, lag[MS_W-1:0]};

	always_comb begin
		res.reached   = !neg && (diff_high || (diff[MS_W-1:0] >= limit));
		res.in_window = !neg && !diff_high && (diff[MS_W-1:0] <= limit);
		if (neg) begin
			// Time ran backwards: the lag adds to the remaining time.
			if (lag_sat || sum[MS_W]) begin
				res.left = TO_SAT;
			end else begin
				res.left = sum[MS_W-1:0];
			end
		end else if (res.reached) begin
			res.left = '0;
		end else begin
			res.left = limit - diff[MS_W-1:0];
		end
	end

endmodule

// ----- src/bgd_core.sv -----
// Gesture state and decision logic, plus the configuration registers.
// Depends on bgd_pkg and bgd_timer.
module bgd_core import bgd_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [MS_W-1:0]      cfg_data,
	input  logic                 fire,
	input  logic [1:0]           action,
	input  logic [1:0]           key_value,
	input  logic [TIME_BITS-1:0] now,
	output logic [1:0]           gesture,
	output logic [TO_W-1:0]      timeout_ms
);

	cfg_t                 cfg_q;
	logic                 key_down_q, long_done_q, click_pending_q;
	logic [TIME_BITS-1:0] press_time_q, release_time_q;

	logic key_down_d, long_done_d, click_pending_d;
	logic set_press, set_release;

	timer_res_t press_res, rel_res;
	logic [MS_W-1:0] best;
	logic            have;

	bgd_timer #(.TIME_BITS(TIME_BITS)) u_press_timer (
		.now   (now),
		.stamp (press_time_q),
		.limit (cfg_q.long_press_ms),
		.res   (press_res)
	);

	bgd_timer #(.TIME_BITS(TIME_BITS)) u_release_timer (
		.now   (now),
		.stamp (release_time_q),
		.limit (cfg_q.double_window_ms),
		.res   (rel_res)
	);

	always_comb begin
		key_down_d      = key_down_q;
		long_done_d     = long_done_q;
		click_pending_d = click_pending_q;
		set_press       = 1'b0;
		set_release     = 1'b0;
		gesture         = G_NONE;
		timeout_ms      = TO_NONE;
		best            = '0;
		have            = 1'b0;
		unique case (action)
			ACT_KEY: begin
				if (key_value == KEY_PRESS) begin
					if (!key_down_q) begin
						key_down_d  = 1'b1;
						long_done_d = 1'b0;
						set_press   = 1'b1;
					end
				end else if (key_value == KEY_RELEASE && key_down_q) begin
					key_down_d = 1'b0;
					if (!long_done_q && press_res.reached) begin
						long_done_d = 1'b1;
						gesture     = G_LONG;
					end else if (long_done_q) begin
						gesture = G_NONE;
					end else if (!cfg_q.dbl_click_en) begin
						click_pending_d = 1'b0;
						gesture         = G_CLICK;
					end else if (click_pending_q) begin
						if (rel_res.in_window) begin
							click_pending_d = 1'b0;
							gesture         = G_DOUBLE;
						end else begin
							// Late second click: report the old one, start a new wait.
							set_release = 1'b1;
							gesture     = G_CLICK;
						end
					end else begin
						click_pending_d = 1'b1;
						set_release     = 1'b1;
					end
				end
			end
			ACT_POLL: begin
				if (click_pending_q && rel_res.reached) begin
					click_pending_d = 1'b0;
					gesture         = G_CLICK;
				end else if (key_down_q && !long_done_q && press_res.reached) begin
					long_done_d = 1'b1;
					gesture     = G_LONG;
				end
			end
			ACT_QUERY: begin
				if (click_pending_q) begin
					best = rel_res.left;
					have = 1'b1;
				end
				if (key_down_q && !long_done_q) begin
					if (!have || press_res.left < best) begin
						best = press_res.left;
					end
					have = 1'b1;
				end
				if (have) begin
					timeout_ms = {1'b0, best};
				end
			end
			default: begin
				gesture = G_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_press_ms    <= LONG_PRESS_RST;
			cfg_q.double_window_ms <= DOUBLE_WINDOW_RST;
			cfg_q.dbl_click_en     <= 1'b1;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_LONG_PRESS:    cfg_q.long_press_ms    <= cfg_data;
				REG_DOUBLE_WINDOW: cfg_q.double_window_ms <= cfg_data;
				REG_DOUBLE_EN:     cfg_q.dbl_click_en     <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_down_q      <= 1'b0;
			long_done_q     <= 1'b0;
			click_pending_q <= 1'b0;
		end else if (fire) begin
			key_down_q      <= key_down_d;
			long_done_q     <= long_done_d;
			click_pending_q <= click_pending_d;
		end
	end

	// The stored times are only read while the flag that set them is high.
	always_ff @(posedge clk) begin
		if (fire && set_press) begin
			press_time_q <= now;
		end
		if (fire && set_release) begin
			release_time_q <= now;
		end
	end

endmodule
